// ===== hw/rtl/mfd_pkg.sv =====
`default_nettype none

package mfd_pkg;

   // Stream framing constants.
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [2:0] SYNC_TOP = 3'b111;

   // Divider size: the largest numerator is 144 * 384 * 1000.
   localparam int NUM_WIDTH = 26;
   localparam int RATE_WIDTH = 16;
   localparam int DIV_STEPS = NUM_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   // Widths of the packed result beat.
   localparam int RSP_DATA_WIDTH = 96;
   localparam int RSP_USER_WIDTH = 2;

   // Length coefficients by layer and version.
   localparam logic [7:0] COEF_LAYER1 = 8'd12;
   localparam logic [7:0] COEF_HALF = 8'd72;
   localparam logic [7:0] COEF_FULL = 8'd144;

   typedef enum logic [2:0] {
      ST_IN,
      ST_CHECK,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_LEN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic mul;
      logic div_load;
      logic div_step;
      logic len;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic in_payload;
      logic fill_is3;
      logic hdr_ok;
      logic div_done;
      logic emit_last;
   } status_type;

   // Bitrate in kbit/s by table row (0 for MPEG-1), layer and index.
   function automatic logic [8:0] kbps_lookup(input logic row, input logic [1:0] lay,
                                              input logic [3:0] idx);
      logic [8:0] v;
      v = 9'd0;
      if (!row && lay == 2'd0) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;   4'd4: v = 9'd128;
            4'd5: v = 9'd160;  4'd6: v = 9'd192;  4'd7: v = 9'd224;  4'd8: v = 9'd256;
            4'd9: v = 9'd288;  4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
            4'd13: v = 9'd416; 4'd14: v = 9'd448;
            default: v = 9'd0;
         endcase
      end else if (!row && lay == 2'd1) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
            4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
            4'd9: v = 9'd160;  4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
            4'd13: v = 9'd320; 4'd14: v = 9'd384;
            default: v = 9'd0;
         endcase
      end else if (!row) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;   4'd4: v = 9'd56;
            4'd5: v = 9'd64;   4'd6: v = 9'd80;   4'd7: v = 9'd96;   4'd8: v = 9'd112;
            4'd9: v = 9'd128;  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
            4'd13: v = 9'd256; 4'd14: v = 9'd320;
            default: v = 9'd0;
         endcase
      end else if (lay == 2'd0) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
            4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
            4'd9: v = 9'd144;  4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
            4'd13: v = 9'd224; 4'd14: v = 9'd256;
            default: v = 9'd0;
         endcase
      end else begin
         unique case (idx)
            4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;   4'd4: v = 9'd32;
            4'd5: v = 9'd40;   4'd6: v = 9'd48;   4'd7: v = 9'd56;   4'd8: v = 9'd64;
            4'd9: v = 9'd80;   4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
            4'd13: v = 9'd144; 4'd14: v = 9'd160;
            default: v = 9'd0;
         endcase
      end
      return v;
   endfunction

   // Sampling rate in Hz by version and rate index.
   function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] ridx);
      logic [15:0] v;
      v = 16'd0;
      unique case ({ver, ridx})
         4'b00_00: v = 16'd44100;
         4'b00_01: v = 16'd48000;
         4'b00_10: v = 16'd32000;
         4'b01_00: v = 16'd22050;
         4'b01_01: v = 16'd24000;
         4'b01_10: v = 16'd16000;
         4'b10_00: v = 16'd11025;
         4'b10_01: v = 16'd12000;
         4'b10_10: v = 16'd8000;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // Samples per frame by table row and layer.
   function automatic logic [10:0] samples_lookup(input logic row, input logic [1:0] lay);
      logic [10:0] v;
      if (lay == 2'd0) begin
         v = 11'd384;
      end else if (lay == 2'd2 && row) begin
         v = 11'd576;
      end else begin
         v = 11'd1152;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfd_ctrl.sv =====
`default_nettype none

module mfd_ctrl
   import mfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IN;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IN: begin
            req_tready = status.out_free;
            cmd.accept = req_tvalid && status.out_free;
            if (cmd.accept && !status.in_payload && status.fill_is3) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in = status.hdr_ok ? ST_MUL : ST_IN;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.len = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_IN;
            end
         end
         default: state_in = ST_IN;
      endcase
   end

`ifndef ASSERT_OFF
   a_ready_only_in_input: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IN)
      else $error("input ready outside the input state");
   a_check_after_fourth: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(cmd.accept))
      else $error("header check without a fourth byte");
   a_emit_follows_len: assert property (@(posedge clock) disable iff (reset)
      cmd.len |=> state_ff == ST_EMIT)
      else $error("length step not followed by header beats");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_dpath.sv =====
`default_nettype none

module mfd_dpath
   import mfd_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cmd_type                     cmd,
   output status_type                       status,
   input  wire logic [7:0]                  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]        rsp_tdata,
   output logic [RSP_USER_WIDTH-1:0]        rsp_tuser,
   output logic                             rsp_tlast
);

   // Header window and control state.
   logic [7:0]                win_ff [4];
   logic [7:0]                win_in [4];
   logic [2:0]                fill_ff, fill_in;
   logic                      pay_ff, pay_in;
   logic [11:0]               left_ff, left_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;

   // Frame info.
   logic [1:0]  ver_ff, ver_in;
   logic [1:0]  lay_ff, lay_in;
   logic [8:0]  kbps_ff, kbps_in;
   logic [15:0] rate_ff, rate_in;
   logic [1:0]  chans_ff, chans_in;
   logic [10:0] samples_ff, samples_in;
   logic [11:0] len_ff, len_in;
   logic [31:0] offset_ff, offset_in;
   logic        pad_ff, pad_in;
   logic [7:0]  coef_ff, coef_in;

   // Length arithmetic.
   logic [18:0]                k1000_ff, k1000_in;
   logic [NUM_WIDTH-1:0]       num_ff, num_in;
   logic [RATE_WIDTH-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [1:0]                 emit_ff, emit_in;

   // Output register.
   logic                       ovalid_ff, ovalid_in;
   logic [7:0]                 obyte_ff, obyte_in;
   logic                       ostart_ff, ostart_in;
   logic                       oend_ff, oend_in;
   logic                       olast_ff, olast_in;

   // Header decode and helpers.
   logic        sync0, sync1, sync2, hdr_ok, row, out_load;
   logic [1:0]  vbits, dver, dlay;
   logic [3:0]  bidx;
   logic [1:0]  ridx;
   logic [26:0] prod;
   logic [RATE_WIDTH:0] trial;
   logic [11:0] qsum, len_calc;
   logic [POSITION_WIDTH-1:0] hdr_pos;

   always_comb begin
      sync0 = win_ff[0] == SYNC_BYTE && win_ff[1][7:5] == SYNC_TOP;
      sync1 = win_ff[1] == SYNC_BYTE && win_ff[2][7:5] == SYNC_TOP;
      sync2 = win_ff[2] == SYNC_BYTE && win_ff[3][7:5] == SYNC_TOP;
      vbits = win_ff[1][4:3];
      dver = (vbits == 2'd3) ? 2'd0 : ((vbits == 2'd2) ? 2'd1 : 2'd2);
      row = dver != 2'd0;
      dlay = 2'd3 - win_ff[1][2:1];
      bidx = win_ff[2][7:4];
      ridx = win_ff[2][3:2];
      hdr_ok = sync0 && vbits != 2'd1 && dlay != 2'd3 && bidx != 4'd0 && bidx != 4'd15
               && ridx != 2'd3;
      hdr_pos = pos_ff - POSITION_WIDTH'(4);
      prod = 27'(coef_ff) * 27'(k1000_ff);
      trial = {rem_ff, num_ff[NUM_WIDTH-1]} - {1'b0, rate_ff};
      qsum = num_ff[11:0] + 12'(pad_ff);
      len_calc = (lay_ff == 2'd0) ? {qsum[9:0], 2'b00} : qsum;
      out_load = (cmd.accept && pay_ff) || cmd.emit;
   end

   // Next values.
   always_comb begin
      win_in = win_ff;
      fill_in = fill_ff;
      pay_in = pay_ff;
      left_in = left_ff;
      pos_in = pos_ff;
      ver_in = ver_ff;
      lay_in = lay_ff;
      kbps_in = kbps_ff;
      rate_in = rate_ff;
      chans_in = chans_ff;
      samples_in = samples_ff;
      len_in = len_ff;
      offset_in = offset_ff;
      pad_in = pad_ff;
      coef_in = coef_ff;
      k1000_in = k1000_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      emit_in = emit_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      obyte_in = obyte_ff;
      ostart_in = ostart_ff;
      oend_in = oend_ff;
      olast_in = olast_ff;

      // Byte intake: payload passes straight to the output register.
      if (cmd.accept) begin
         pos_in = pos_ff + POSITION_WIDTH'(1);
         if (pay_ff) begin
            left_in = (left_ff != 12'd0) ? left_ff - 12'd1 : 12'd0;
            pay_in = left_in != 12'd0;
            obyte_in = req_tdata;
            ostart_in = 1'b0;
            oend_in = left_in == 12'd0;
            olast_in = 1'b1;
         end else begin
            win_in[fill_ff[1:0]] = req_tdata;
            fill_in = fill_ff + 3'd1;
         end
      end

      // Header check: latch the frame info or realign the window.
      if (cmd.check) begin
         if (hdr_ok) begin
            ver_in = dver;
            lay_in = dlay;
            kbps_in = kbps_lookup(row, dlay, bidx);
            rate_in = rate_lookup(dver, ridx);
            chans_in = (win_ff[3][7:6] == 2'd3) ? 2'd1 : 2'd2;
            samples_in = samples_lookup(row, dlay);
            pad_in = win_ff[2][1];
            offset_in = 32'(hdr_pos);
            coef_in = (dlay == 2'd0) ? COEF_LAYER1 :
                      ((row && dlay == 2'd2) ? COEF_HALF : COEF_FULL);
            fill_in = 3'd0;
         end else if (sync1) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            fill_in = 3'd3;
         end else if (sync2) begin
            win_in[0] = win_ff[2];
            win_in[1] = win_ff[3];
            fill_in = 3'd2;
         end else if (win_ff[3] == SYNC_BYTE) begin
            win_in[0] = win_ff[3];
            fill_in = 3'd1;
         end else begin
            fill_in = 3'd0;
         end
      end

      // Numerator in two multiply stages.
      if (cmd.mul) begin
         k1000_in = 19'(kbps_ff) * 19'd1000;
      end
      if (cmd.div_load) begin
         num_in = prod[NUM_WIDTH-1:0];
         rem_in = '0;
         cnt_in = '0;
      end

      // One restoring division step per cycle; quotient bits shift into num.
      if (cmd.div_step) begin
         if (!trial[RATE_WIDTH]) begin
            rem_in = trial[RATE_WIDTH-1:0];
         end else begin
            rem_in = {rem_ff[RATE_WIDTH-2:0], num_ff[NUM_WIDTH-1]};
         end
         num_in = {num_ff[NUM_WIDTH-2:0], !trial[RATE_WIDTH]};
         cnt_in = cnt_ff + DIV_CNT_WIDTH'(1);
      end

      // Frame length and payload count.
      if (cmd.len) begin
         len_in = len_calc;
         left_in = (len_calc > 12'd4) ? len_calc - 12'd4 : 12'd0;
         pay_in = len_calc > 12'd4;
         emit_in = 2'd0;
      end

      // Header beats from the window.
      if (cmd.emit) begin
         obyte_in = win_ff[emit_ff];
         ostart_in = emit_ff == 2'd0;
         oend_in = emit_ff == 2'd3 && !pay_ff;
         olast_in = emit_ff == 2'd3;
         emit_in = emit_ff + 2'd1;
      end

      if (out_load) begin
         ovalid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
         pay_ff <= 1'b0;
         left_ff <= 12'd0;
         pos_ff <= '0;
         ovalid_ff <= 1'b0;
         ver_ff <= 2'd0;
         lay_ff <= 2'd0;
         kbps_ff <= 9'd0;
         rate_ff <= 16'd0;
         chans_ff <= 2'd0;
         samples_ff <= 11'd0;
         len_ff <= 12'd0;
         offset_ff <= 32'd0;
      end else begin
         fill_ff <= fill_in;
         pay_ff <= pay_in;
         left_ff <= left_in;
         pos_ff <= pos_in;
         ovalid_ff <= ovalid_in;
         ver_ff <= ver_in;
         lay_ff <= lay_in;
         kbps_ff <= kbps_in;
         rate_ff <= rate_in;
         chans_ff <= chans_in;
         samples_ff <= samples_in;
         len_ff <= len_in;
         offset_ff <= offset_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      pad_ff <= pad_in;
      coef_ff <= coef_in;
      k1000_ff <= k1000_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      emit_ff <= emit_in;
      obyte_ff <= obyte_in;
      ostart_ff <= ostart_in;
      oend_ff <= oend_in;
      olast_ff <= olast_in;
   end

   // Status and result beat.
   always_comb begin
      status.out_free = !ovalid_ff || rsp_tready;
      status.in_payload = pay_ff;
      status.fill_is3 = fill_ff == 3'd3;
      status.hdr_ok = hdr_ok;
      status.div_done = cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1);
      status.emit_last = emit_ff == 2'd3;
      rsp_tvalid = ovalid_ff;
      rsp_tlast = olast_ff;
      rsp_tuser = {oend_ff, ostart_ff};
      rsp_tdata = {2'b00, offset_ff, len_ff, samples_ff, chans_ff, rate_ff, kbps_ff,
                   lay_ff, ver_ff, obyte_ff};
   end

`ifndef ASSERT_OFF
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'd4)
      else $error("header window overfilled");
   a_payload_empty_window: assert property (@(posedge clock) disable iff (reset)
      pay_ff |-> fill_ff == 3'd0)
      else $error("window holds bytes during payload");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(ovalid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mp3_frame_deframer_top.sv =====
// Payload: one byte per cycle unless the receiver stalls; each result is registered
// in the cycle after its byte is taken. Header: after the fourth byte, the check, two
// multiply stages and a 26-step restoring divider for the frame length, then four header
// beats, one a cycle unless the receiver stalls. No byte is taken while the divider runs.
// Reset is synchronous and active high; it clears control and frame info, not the window.
`default_nettype none

module mp3_frame_deframer_top
   import mfd_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,  // data_byte[7:0]
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // out_byte[7:0], mpeg_version[9:8], layer_code[11:10], bitrate_kbps[20:12],
   // sample_rate_hz[36:21], channel_count[38:37], samples_per_frame[49:39],
   // frame_bytes[61:50], frame_offset[93:62], zero fill[95:94]
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic [RSP_USER_WIDTH-1:0]      rsp_tuser,  // frame_start[0], frame_end[1]
   output logic                           rsp_tlast   // last_of_run
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   mfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Window, decode, divider and result register.
   mfd_dpath #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== verif/tb_mp3_frame_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_mp3_frame_deframer_top;
   import mfd_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_BYTES = 40;

   // One beat of the result channel as the block should produce it.
   typedef struct {
      logic [7:0]  out_byte;
      logic        frame_start;
      logic        frame_end;
      logic        last_of_run;
      logic [1:0]  mpeg_version;
      logic [1:0]  layer_code;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [1:0]  channel_count;
      logic [10:0] samples_per_frame;
      logic [11:0] frame_bytes;
      logic [31:0] frame_offset;
   } frame_beat_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;
   logic                      rsp_tlast;

   mp3_frame_deframer_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Shadow state of the deframer.
   logic [7:0]  win [4];
   int unsigned win_fill;
   logic        pay_active;
   int unsigned pay_left;
   frame_beat_type cur_frame;
   logic [31:0] byte_pos;

   frame_beat_type expected_beats[$];
   int          mismatch_count;
   int          beats_checked;
   int          frames_seen;
   int          bytes_sent;
   int          send_idle_pct;
   int          recv_idle_pct;

   function automatic logic [8:0] kbps_of(input logic row, input logic [1:0] lay,
                                          input logic [3:0] idx);
      int t [2][3][16] = '{
         '{'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
           '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
           '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}},
         '{'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
           '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
           '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}}};
      return 9'(t[row][lay][idx]);
   endfunction

   function automatic logic is_sync(input int i);
      return win[i] == 8'hFF && win[i + 1][7:5] == 3'b111;
   endfunction

   // Advance the shadow deframer by one stream byte and queue the beats it causes.
   task automatic predict_byte(input logic [7:0] b);
      logic [31:0] pos;
      logic [1:0]  vbits;
      logic [1:0]  ver;
      logic [1:0]  lay;
      logic [3:0]  bidx;
      logic [1:0]  ridx;
      logic        row;
      int unsigned rate;
      int unsigned kb;
      int unsigned len;
      int unsigned shift;
      int          rates [3][3] = '{'{44100, 48000, 32000}, '{22050, 24000, 16000},
                                    '{11025, 12000, 8000}};
      frame_beat_type e;
      pos = byte_pos;
      byte_pos = byte_pos + 1;
      if (pay_active) begin
         if (pay_left > 0) pay_left--;
         e = cur_frame;
         e.out_byte = b;
         e.frame_start = 1'b0;
         e.frame_end = (pay_left == 0);
         e.last_of_run = 1'b1;
         if (pay_left == 0) pay_active = 1'b0;
         expected_beats.push_back(e);
         return;
      end
      win[win_fill] = b;
      win_fill++;
      if (win_fill < 4) return;
      vbits = win[1][4:3];
      lay = 2'(3 - win[1][2:1]);
      bidx = win[2][7:4];
      ridx = win[2][3:2];
      if (is_sync(0) && vbits != 2'd1 && win[1][2:1] != 2'd0 && bidx != 4'd0 &&
          bidx != 4'd15 && ridx != 2'd3) begin
         ver = (vbits == 2'd3) ? 2'd0 : (vbits == 2'd2 ? 2'd1 : 2'd2);
         row = (ver != 2'd0);
         kb = kbps_of(row, lay, bidx);
         rate = rates[ver][ridx];
         if (lay == 2'd0) len = (12 * kb * 1000 / rate + win[2][1]) * 4;
         else if (ver > 0 && lay == 2'd2) len = 72 * kb * 1000 / rate + win[2][1];
         else len = 144 * kb * 1000 / rate + win[2][1];
         len = len & 12'hFFF;
         cur_frame.mpeg_version = ver;
         cur_frame.layer_code = lay;
         cur_frame.bitrate_kbps = 9'(kb);
         cur_frame.sample_rate_hz = 16'(rate);
         cur_frame.channel_count = (win[3][7:6] == 2'd3) ? 2'd1 : 2'd2;
         cur_frame.samples_per_frame = (lay == 2'd0) ? 11'd384 :
                                       ((lay == 2'd2 && row) ? 11'd576 : 11'd1152);
         cur_frame.frame_bytes = 12'(len);
         cur_frame.frame_offset = pos - 32'd3;
         pay_left = (len > 4) ? len - 4 : 0;
         pay_active = (pay_left != 0);
         win_fill = 0;
         frames_seen++;
         for (int k = 0; k < 4; k++) begin
            e = cur_frame;
            e.out_byte = win[k];
            e.frame_start = (k == 0);
            e.frame_end = (k == 3) && (pay_left == 0);
            e.last_of_run = (k == 3);
            expected_beats.push_back(e);
         end
         return;
      end
      // Resync: slide to a plausible sync start, keep a trailing 0xFF, or empty.
      if (is_sync(1)) shift = 1;
      else if (is_sync(2)) shift = 2;
      else if (win[3] == 8'hFF) shift = 3;
      else shift = 4;
      if (shift >= 4) begin
         win_fill = 0;
      end else begin
         win_fill = 4 - shift;
         for (int k = 0; k < 4 - shift; k++) win[k] = win[k + shift];
      end
   endtask

   // Directed stream: short frames of each version, bad headers and resync cases.
   // Each row is one header; the payload bytes of valid rows are sent by the loop.
   typedef struct {
      logic [31:0] hdr;
      logic        valid;
      logic [11:0] len;
   } hdr_row_type;

   hdr_row_type hdr_rows [$] = '{
      '{32'hFFF3_1400, 1'b1, 12'd24},   // MPEG-2 layer III 8k 24k
      '{32'hFFFF_1400, 1'b1, 12'd32},   // MPEG-1 layer I 32k 48k
      '{32'hFFE3_16C0, 1'b1, 12'd49},   // MPEG-2.5 layer III 8k 12k padded, mono
      '{32'hFFF7_0000, 1'b0, 12'd0},    // bitrate index zero
      '{32'hFFFB_F000, 1'b0, 12'd0},    // bitrate index fifteen
      '{32'hFFFB_9C00, 1'b0, 12'd0},    // rate index three
      '{32'hFFEB_9000, 1'b0, 12'd0},    // reserved version
      '{32'hFFF9_9000, 1'b0, 12'd0},    // reserved layer
      '{32'h00FF_FF00, 1'b0, 12'd0},    // sync at slot one
      '{32'h1234_56FF, 1'b0, 12'd0}     // lone 0xFF kept
   };

   logic [7:0] stream_bytes[$];

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic push_frame(input logic [31:0] hdr, input int plen);
      for (int k = 3; k >= 0; k--) stream_bytes.push_back(hdr[8*k +: 8]);
      for (int k = 0; k < plen; k++) stream_bytes.push_back(8'($urandom));
   endtask

   // A random valid header at the lowest bitrates, which keeps the frames short.
   function automatic logic [31:0] random_header();
      logic [1:0] vb;
      logic [1:0] lb;
      logic [3:0] bi;
      vb = ($urandom_range(2) == 0) ? 2'd0 : ($urandom_range(1) ? 2'd2 : 2'd3);
      lb = 2'($urandom_range(3, 1));
      bi = ($urandom_range(3) == 0) ? 4'd2 : 4'd1;
      return {8'hFF, 3'b111, vb, lb, 1'($urandom), bi, 2'($urandom_range(2)),
              2'($urandom), 8'($urandom)};
   endfunction

   // Result side: compare every accepted beat against the oldest expectation.
   always @(posedge clock) begin
      frame_beat_type e;
      logic        bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected beat: data %h", rsp_tdata);
         end else begin
            e = expected_beats.pop_front();
            bad = rsp_tdata[7:0] !== e.out_byte || rsp_tuser[0] !== e.frame_start ||
                  rsp_tuser[1] !== e.frame_end || rsp_tlast !== e.last_of_run ||
                  rsp_tdata[9:8] !== e.mpeg_version || rsp_tdata[11:10] !== e.layer_code ||
                  rsp_tdata[20:12] !== e.bitrate_kbps ||
                  rsp_tdata[36:21] !== e.sample_rate_hz ||
                  rsp_tdata[38:37] !== e.channel_count ||
                  rsp_tdata[49:39] !== e.samples_per_frame ||
                  rsp_tdata[61:50] !== e.frame_bytes ||
                  rsp_tdata[93:62] !== e.frame_offset || rsp_tdata[95:94] !== 2'b00;
            beats_checked++;
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp byte %h s%b e%b l%b v%0d y%0d %0dk %0dHz",
                           e.out_byte, e.frame_start, e.frame_end, e.last_of_run,
                           e.mpeg_version, e.layer_code, e.bitrate_kbps,
                           e.sample_rate_hz);
                  $display("   c%0d n%0d len %0d off %0d; got tdata %h tuser %b tlast %b",
                           e.channel_count, e.samples_per_frame, e.frame_bytes,
                           e.frame_offset, rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles without any accepted beat.
   int stall_count;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog timeout, %0d beats outstanding", expected_beats.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int phase_len;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      rsp_tready = 1'b0;
      send_idle_pct = 28;
      recv_idle_pct = 45;
      win_fill = 0;
      pay_active = 1'b0;
      pay_left = 0;
      cur_frame = '{default: '0};
      byte_pos = 32'd0;
      mismatch_count = 0;
      beats_checked = 0;
      frames_seen = 0;
      bytes_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; the known frame lengths are checked against the predictor.
      foreach (hdr_rows[i]) begin
         int frames_prior;
         int plen;
         frames_prior = frames_seen;
         for (int k = 3; k >= 0; k--) send_byte(hdr_rows[i].hdr[8*k +: 8]);
         if (hdr_rows[i].valid && (frames_seen == frames_prior ||
             (hdr_rows[i].len != 0 && cur_frame.frame_bytes != hdr_rows[i].len))) begin
            mismatch_count++;
            $display("directed header %h: frame length %0d, table says %0d",
                     hdr_rows[i].hdr, cur_frame.frame_bytes, hdr_rows[i].len);
         end
         if (!hdr_rows[i].valid && frames_seen != frames_prior) mismatch_count++;
         plen = pay_active ? pay_left : 0;
         for (int k = 0; k < plen; k++) send_byte(8'($urandom));
         // Flush any bytes left in the window after an invalid row.
         while (win_fill != 0) send_byte(8'h00);
      end

      // Random part in three idling phases: mostly valid frames, some noise.
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 28 : (p == 1 ? 45 : 0);
         recv_idle_pct = (p == 0) ? 45 : (p == 1 ? 28 : 0);
         phase_len = 0;
         while (phase_len < PHASE_BYTES) begin
            stream_bytes.delete();
            case ($urandom_range(9))
               0: for (int k = 0; k < 6; k++) stream_bytes.push_back(8'($urandom));
               1: begin
                  stream_bytes.push_back(8'hFF);
                  push_frame(random_header(), 0);
               end
               2: push_frame(random_header() ^ (32'h1 << $urandom_range(31, 11)), 0);
               default: push_frame(random_header(), 0);
            endcase
            foreach (stream_bytes[k]) send_byte(stream_bytes[k]);
            // Finish the frame in progress with random payload.
            while (pay_active) begin
               send_byte(8'($urandom));
               phase_len++;
            end
            phase_len += stream_bytes.size();
         end
      end
      req_tvalid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d stream bytes holding %0d frames; %0d result beats compared.",
               bytes_sent, frames_seen, beats_checked);
      $display("Covered all versions and layers, bad header fields and resync slides.");
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_ctrl.sv
hw/rtl/mfd_dpath.sv
hw/rtl/mp3_frame_deframer_top.sv
verif/tb_mp3_frame_deframer_top.sv
